[src/dtsp_pkg.sv]
// Package for the digit table shuffle generator: widths, mode codes,
// controller/datapath command and status types. No dependencies.
package dtsp_pkg;

  localparam int TABLE_DEPTH_DEF = 1000;
  localparam int PTR_W           = 10;
  localparam int DIGIT_W         = 4;
  localparam int NUM_W           = 16;
  localparam int MODE_W          = 2;
  localparam int DCNT_W          = 2;
  localparam int POS_W           = PTR_W + 1;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GEN  = 2'd2;

  localparam logic [PTR_W-1:0]  RESEED_MARK = 10'd999;
  localparam logic [DCNT_W-1:0] LAST_DIGIT  = 2'd3;

  typedef struct packed {
    logic              load;       // write one table digit
    logic              set_ptr;    // overwrite pointer
    logic              gen_start;  // clear accumulators, latch reseed
    logic              capture;    // take one digit this cycle
    logic              from_ram;   // digit comes from RAM read data (swap)
    logic              last;       // fourth digit of the step
    logic [DCNT_W-1:0] digit_idx;  // offset from pointer
  } dtsp_cmd_t;

  typedef struct packed {
    logic in_ram;  // current position is a RAM entry (1..depth-1)
  } dtsp_stat_t;

endpackage

[src/dtsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtsp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/dtsp_ctrl.sv]
// Controller for the digit table shuffle generator: command decode,
// per-digit issue/swap sequencing. Uses dtsp_pkg.
module dtsp_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dtsp_pkg::MODE_W-1:0] mode,
  input  dtsp_pkg::dtsp_stat_t       stat,
  output dtsp_pkg::dtsp_cmd_t        cmd,
  output logic                       busy
);
  import dtsp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_SWAP  = 2'd2;

  logic [1:0]        state, state_next;
  logic [DCNT_W-1:0] k, k_next;
  logic              accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next        = state;
    k_next            = k;
    cmd               = '0;
    cmd.digit_idx     = k;
    cmd.last          = (k == LAST_DIGIT);
    cmd.load          = accept && (mode == MODE_LOAD);
    cmd.set_ptr       = accept && (mode == MODE_SET);
    cmd.gen_start     = accept && (mode == MODE_GEN);
    case (state)
      S_IDLE: begin
        if (cmd.gen_start) begin
          state_next = S_ISSUE;
          k_next     = '0;
        end
      end
      S_ISSUE: begin
        if (stat.in_ram) begin
          state_next = S_SWAP;
        end else begin
          // position 0 or past the table end: digit is entry zero, no swap
          cmd.capture = 1'b1;
          k_next      = k + 1'b1;
          if (k == LAST_DIGIT) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SWAP: begin
        cmd.capture  = 1'b1;
        cmd.from_ram = 1'b1;
        k_next       = k + 1'b1;
        state_next   = (k == LAST_DIGIT) ? S_IDLE : S_ISSUE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

`ifndef SYNTHESIS
  a_swap_after_issue: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP) |-> ($past(state) == S_ISSUE))
    else $error("swap entered without a read issue");

  a_swap_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP && k != LAST_DIGIT) |=> (state == S_ISSUE && k == $past(k) + 1'b1))
    else $error("digit index did not advance after swap");

  a_gen_enters_issue: assert property (@(posedge clk) disable iff (rst)
    cmd.gen_start |=> (state == S_ISSUE && k == '0))
    else $error("step did not start at first digit");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load || cmd.set_ptr) |-> (state == S_IDLE && !cmd.capture))
    else $error("table or pointer write during a step");
`endif

endmodule

[src/dtsp_dpath.sv]
// Datapath for the digit table shuffle generator: pointer, entry-zero
// register, digit table RAM, number and next-pointer build. Uses dtsp_pkg, dtsp_ram.
module dtsp_dpath #(
  parameter int TABLE_DEPTH = dtsp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dtsp_pkg::dtsp_cmd_t          cmd,
  output dtsp_pkg::dtsp_stat_t         stat,
  input  logic [dtsp_pkg::PTR_W-1:0]   load_index,
  input  logic [dtsp_pkg::DIGIT_W-1:0] load_digit,
  input  logic [dtsp_pkg::PTR_W-1:0]   start_pointer,
  input  logic [dtsp_pkg::PTR_W-1:0]   reseed_pointer,
  output logic                         done,
  output logic [dtsp_pkg::NUM_W-1:0]   number,
  output logic [dtsp_pkg::PTR_W-1:0]   next_pointer
);
  import dtsp_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(TABLE_DEPTH);

  logic [PTR_W-1:0]   ptr;
  logic [DIGIT_W-1:0] zero_entry;   // table entry zero lives here
  logic [PTR_W-1:0]   reseed;
  logic [PTR_W-1:0]   acc;          // first three digits as decimal, mod 1024
  logic [NUM_W-DIGIT_W-1:0] digits; // earlier digits of this step
  logic [POS_W-1:0]   pos;
  logic [DIGIT_W-1:0] ram_rdata;
  logic [DIGIT_W-1:0] d;
  logic [PTR_W-1:0]   acc_x10;
  logic [PTR_W-1:0]   ptr_new;
  logic               load_in_ram;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DIGIT_W-1:0] ram_wdata;

  assign pos = {1'b0, ptr} + {{(POS_W-DCNT_W){1'b0}}, cmd.digit_idx};
  assign stat.in_ram = (pos != '0) && (pos < DEPTH_POS);

  assign load_in_ram = cmd.load && (load_index != '0) && ({1'b0, load_index} < DEPTH_POS);

  assign ram_we    = load_in_ram || (cmd.capture && cmd.from_ram);
  assign ram_waddr = cmd.load ? load_index[AW-1:0] : pos[AW-1:0];
  assign ram_wdata = cmd.load ? load_digit : zero_entry;

  dtsp_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign d       = cmd.from_ram ? ram_rdata : zero_entry;
  assign acc_x10 = {acc[PTR_W-4:0], 3'b000} + {acc[PTR_W-2:0], 1'b0};
  assign ptr_new = (acc == RESEED_MARK) ? reseed : acc;

  always_ff @(posedge clk) begin
    if (cmd.load && load_index == '0) begin
      zero_entry <= load_digit;
    end else if (cmd.capture && cmd.from_ram) begin
      zero_entry <= ram_rdata;
    end
    if (cmd.gen_start) begin
      reseed <= reseed_pointer;
      acc    <= '0;
    end else if (cmd.capture && !cmd.last) begin
      acc <= acc_x10 + {{(PTR_W-DIGIT_W){1'b0}}, d};
    end
    if (cmd.capture) begin
      digits <= {digits[NUM_W-2*DIGIT_W-1:0], d};
    end
    if (cmd.capture && cmd.last) begin
      number       <= {digits, d};
      next_pointer <= ptr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.capture && cmd.last;
      if (cmd.set_ptr) begin
        ptr <= start_pointer;
      end else if (cmd.capture && cmd.last) begin
        ptr <= ptr_new;
      end
    end
  end

endmodule

[src/digit_table_shuffle_prng_unit.sv]
// Top level of the digit table shuffle generator.
// Uses dtsp_pkg, dtsp_ctrl, dtsp_dpath (which holds dtsp_ram).
//
// Usage:
//   A command word (mode, load_index, load_digit, start_pointer,
//   reseed_pointer) is taken at a rising edge with start high and busy low.
//   mode 0 writes one table digit, mode 1 sets the pointer; both finish at
//   the accepting edge, busy stays low and no result is given. Mode 3 is
//   ignored.
//   mode 2 runs one step: four digits at pointer..pointer+3. Each position
//   inside the table (1..depth-1) uses the RAM port in an issue state that
//   reads, then a swap state that takes the read data and writes back
//   entry zero's old value. Entry zero sits in a register, so position
//   zero and positions past the end take the issue state only.
//   The result word (number, next_pointer) is shown with done high for
//   exactly one cycle, the cycle after the last digit; busy is already low
//   then, so the next command may be accepted in that same cycle.
//   The receiver cannot hold results off; nothing waits on it.
//   Reset (rst, synchronous) clears the pointer and the sequencer; the
//   table contents are undefined until software loads them.
module digit_table_shuffle_prng_unit #(
  parameter int TABLE_DEPTH = dtsp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [dtsp_pkg::MODE_W-1:0]  mode,
  input  logic [dtsp_pkg::PTR_W-1:0]   load_index,
  input  logic [dtsp_pkg::DIGIT_W-1:0] load_digit,
  input  logic [dtsp_pkg::PTR_W-1:0]   start_pointer,
  input  logic [dtsp_pkg::PTR_W-1:0]   reseed_pointer,
  output logic                         done,
  output logic [dtsp_pkg::NUM_W-1:0]   number,
  output logic [dtsp_pkg::PTR_W-1:0]   next_pointer
);
  import dtsp_pkg::*;

  dtsp_cmd_t  cmd;
  dtsp_stat_t stat;

  // sequencer: decode, per-digit read/swap stepping
  dtsp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table RAM, entry-zero register, pointer and result registers
  dtsp_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .load_index     (load_index),
    .load_digit     (load_digit),
    .start_pointer  (start_pointer),
    .reseed_pointer (reseed_pointer),
    .done           (done),
    .number         (number),
    .next_pointer   (next_pointer)
  );

endmodule

[bench/testbench.sv]
// Self-checking bench for the digit table shuffle generator.
// Drives command words, predicts every result word and checks it.
// Depends on dtsp_pkg and digit_table_shuffle_prng_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dtsp_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  // mode 3 has no name in the package; the block must ignore it
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TOP = 4'hF;
  localparam logic [PTR_W-1:0] PTR_TOP = 10'h3FF;
  // limit for the watchdog; covers the slowest steps and the longest gaps
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_WORDS = 280;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PTR_W-1:0]   load_index;
    logic [DIGIT_W-1:0] load_digit;
    logic [PTR_W-1:0]   start_pointer;
    logic [PTR_W-1:0]   reseed_pointer;
  } cmd_word_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [PTR_W-1:0] next_pointer;
  } gen_word_t;

  // all inputs known from time zero
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [MODE_W-1:0]   mode = MODE_LOAD;
  logic [PTR_W-1:0]    load_index = '0;
  logic [DIGIT_W-1:0]  load_digit = '0;
  logic [PTR_W-1:0]    start_pointer = '0;
  logic [PTR_W-1:0]    reseed_pointer = '0;
  logic                busy;
  logic                done;
  logic [NUM_W-1:0]    number;
  logic [PTR_W-1:0]    next_pointer;

  // shadow copy of the block's state
  logic [DIGIT_W-1:0]  shadow_table [DEPTH];
  logic [PTR_W-1:0]    shadow_ptr = '0;
  gen_word_t           pending_gens [$];
  gen_word_t           oldest_gen;

  logic no_idle = 1'b0;
  int   error_count = 0;
  int   cycle_count = 0;
  int   n_checked = 0;
  int   n_loads = 0;
  int   n_dropped_loads = 0;
  int   n_sets = 0;
  int   n_steps = 0;
  int   n_reseeds = 0;
  int   n_ignored = 0;

  digit_table_shuffle_prng_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .load_index     (load_index),
    .load_digit     (load_digit),
    .start_pointer  (start_pointer),
    .reseed_pointer (reseed_pointer),
    .done           (done),
    .number         (number),
    .next_pointer   (next_pointer)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_gens.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0d] MISMATCH: %s", cycle_count, msg);
  endtask

  // One position of a step: inside the table the digit trades places with
  // entry zero; past the end, entry zero is read and left alone.
  function automatic logic [DIGIT_W-1:0] take_digit(int pos);
    logic [DIGIT_W-1:0] d;
    if (pos < DEPTH) begin
      d = shadow_table[pos];
      shadow_table[pos] = shadow_table[0];
      shadow_table[0] = d;
    end else begin
      d = shadow_table[0];
    end
    return d;
  endfunction

  // Apply one accepted word to the shadow state; steps queue a result word.
  function automatic void shadow_apply(cmd_word_t w);
    logic [DIGIT_W-1:0] dg [4];
    int k;
    int sum;
    gen_word_t r;
    case (w.mode)
      MODE_LOAD: begin
        n_loads++;
        if (int'(w.load_index) < DEPTH) shadow_table[w.load_index] = w.load_digit;
        else n_dropped_loads++;
      end
      MODE_SET: begin
        n_sets++;
        shadow_ptr = w.start_pointer;
      end
      MODE_GEN: begin
        n_steps++;
        for (k = 0; k < 4; k++) dg[k] = take_digit(int'(shadow_ptr) + k);
        r.number = {dg[0], dg[1], dg[2], dg[3]};
        // digits above nine can push the sum past the pointer width
        sum = int'(dg[0]) * 100 + int'(dg[1]) * 10 + int'(dg[2]);
        r.next_pointer = sum[PTR_W-1:0];
        if (r.next_pointer == RESEED_MARK) begin
          r.next_pointer = w.reseed_pointer;
          n_reseeds++;
        end
        shadow_ptr = r.next_pointer;
        pending_gens.push_back(r);
      end
      default: n_ignored++;
    endcase
  endfunction

  // Gap after a word: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Called at a rising edge. Holds start until an edge with busy low takes
  // the word; start stays high into the next word when there is no gap.
  task automatic send_word(cmd_word_t w);
    int gap;
    gap = pick_gap();
    start          <= 1'b1;
    mode           <= w.mode;
    load_index     <= w.load_index;
    load_digit     <= w.load_digit;
    start_pointer  <= w.start_pointer;
    reseed_pointer <= w.reseed_pointer;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow_apply(w);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Fields the mode does not use still carry random bits.
  function automatic cmd_word_t noise_word(logic [MODE_W-1:0] m);
    cmd_word_t w;
    w.mode           = m;
    w.load_index     = PTR_W'($urandom_range(0, 1023));
    w.load_digit     = DIGIT_W'($urandom_range(0, 15));
    w.start_pointer  = PTR_W'($urandom_range(0, 1023));
    w.reseed_pointer = PTR_W'($urandom_range(0, 1023));
    return w;
  endfunction

  task automatic do_load(logic [PTR_W-1:0] idx, logic [DIGIT_W-1:0] dig);
    cmd_word_t w;
    w = noise_word(MODE_LOAD);
    w.load_index = idx;
    w.load_digit = dig;
    send_word(w);
  endtask

  task automatic do_set(logic [PTR_W-1:0] p);
    cmd_word_t w;
    w = noise_word(MODE_SET);
    w.start_pointer = p;
    send_word(w);
  endtask

  task automatic do_gen(logic [PTR_W-1:0] reseed);
    cmd_word_t w;
    w = noise_word(MODE_GEN);
    w.reseed_pointer = reseed;
    send_word(w);
  endtask

  // Plant 9,9,9 at p so the step computes the reseed mark.
  task automatic plant_reseed(logic [PTR_W-1:0] p, logic [PTR_W-1:0] reseed);
    do_load(p, DIGIT_NINE);
    do_load(p + 10'd1, DIGIT_NINE);
    do_load(p + 10'd2, DIGIT_NINE);
    do_set(p);
    do_gen(reseed);
  endtask

  // Result side: done marks one word for one cycle, no way to stall it.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_gens.size() == 0) begin
        report_mismatch($sformatf("result word %h/%0d with no step outstanding",
                                  number, next_pointer));
      end else begin
        oldest_gen = pending_gens.pop_front();
        n_checked++;
        if (number !== oldest_gen.number)
          report_mismatch($sformatf("number %h, expected %h",
                                    number, oldest_gen.number));
        if (next_pointer !== oldest_gen.next_pointer)
          report_mismatch($sformatf("next_pointer %0d, expected %0d",
                                    next_pointer, oldest_gen.next_pointer));
      end
    end
  end

  // Every entry gets a digit before any step reads the table.
  task automatic test_fill_table();
    int i;
    for (i = 0; i < DEPTH; i++) do_load(i[PTR_W-1:0], DIGIT_W'($urandom_range(0, 9)));
  endtask

  // Loads past the table end, a wide digit at the last entry, steps that
  // run off the end, a step at entry zero, a pointer left beyond the table.
  task automatic test_table_edges();
    do_load(PTR_TOP, DIGIT_TOP);
    do_load(10'd1000, 4'd5);
    do_load(10'd999, DIGIT_TOP);
    do_set(10'd997);
    do_gen(PTR_W'($urandom_range(0, 1023)));
    do_set(10'd0);
    do_gen(PTR_W'($urandom_range(0, 1023)));
    do_set(PTR_TOP);
    do_gen(PTR_W'($urandom_range(0, 1023)));
  endtask

  // Reseed at both ends of the pointer range; the step after the last one
  // starts from the reseeded pointer.
  task automatic test_reseed();
    plant_reseed(PTR_W'($urandom_range(1, 996)), 10'd0);
    plant_reseed(PTR_W'($urandom_range(1, 996)), PTR_TOP);
    do_gen(PTR_W'($urandom_range(0, 1023)));
  endtask

  // Mode 3 must leave state alone and give nothing.
  task automatic test_unused_mode();
    send_word(noise_word(MODE_NONE));
    send_word(noise_word(MODE_NONE));
    do_gen(PTR_W'($urandom_range(0, 1023)));
  endtask

  // Mostly steps that chain through the table, mixed with loads, pointer
  // moves, planted reseeds and ignored words; idle-free stretches now and then.
  task automatic test_random();
    int sent;
    int r;
    logic [PTR_W-1:0] idx;
    logic [DIGIT_W-1:0] dig;
    logic [PTR_W-1:0] p;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        p = PTR_W'($urandom_range(0, 996));
        plant_reseed(p, PTR_W'($urandom_range(0, 1023)));
        sent += 5;
      end else if (r < 55) begin
        do_gen(PTR_W'($urandom_range(0, 1023)));
        sent++;
      end else if (r < 75) begin
        idx = PTR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(1000, 1023)
                                                 : $urandom_range(0, 999));
        dig = DIGIT_W'(($urandom_range(0, 6) == 0) ? $urandom_range(10, 15)
                                                   : $urandom_range(0, 9));
        do_load(idx, dig);
        sent++;
      end else if (r < 93) begin
        p = PTR_W'(($urandom_range(0, 4) == 0) ? $urandom_range(990, 1023)
                                               : $urandom_range(0, 999));
        do_set(p);
        sent++;
      end else begin
        send_word(noise_word(MODE_NONE));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_fill_table();
    test_table_edges();
    test_reseed();
    test_unused_mode();
    test_random();
    start <= 1'b0;
    // let the last step finish, then watch for stray strobes
    while (pending_gens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d loads (%0d past the table), %0d pointer sets, %0d ignored words",
             n_loads, n_dropped_loads, n_sets, n_ignored);
    $display("covered %0d steps (%0d reseeded), %0d result words checked in %0d cycles",
             n_steps, n_reseeds, n_checked, cycle_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
